>>> sv/lcd_window_command_generator_top_defines.svh
// assertion macros for the lcd window command generator
// used by the checker bound to the top level; no other dependencies
`ifndef LCD_WINDOW_COMMAND_GENERATOR_TOP_DEFINES_SVH
`define LCD_WINDOW_COMMAND_GENERATOR_TOP_DEFINES_SVH

// implication checked in the same cycle, off while reset is high
`define LWCG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lwcg assertion failed");

// implication checked in the next cycle, off while reset is high
`define LWCG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lwcg assertion failed");

// implication checked in the next cycle, active during reset too
`define LWCG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lwcg assertion failed");

`endif

>>> sv/lwcg_pkg.sv
// shared types and constants for the lcd window command generator
// no dependencies
package lwcg_pkg;

   localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
   localparam logic [7:0] CMD_PAGE_SET   = 8'h2B;

   localparam logic [11:0] PANEL_WIDTH_RESET  = 12'd240;
   localparam logic [11:0] PANEL_HEIGHT_RESET = 12'd320;

   // configuration register indexes
   localparam logic CSR_PANEL_WIDTH  = 1'b0;
   localparam logic CSR_PANEL_HEIGHT = 1'b1;

   // byte positions inside one ten-byte run
   typedef enum logic [3:0] {
      STEP_COL_CMD   = 4'd0,
      STEP_COL_SH    = 4'd1,
      STEP_COL_SL    = 4'd2,
      STEP_COL_EH    = 4'd3,
      STEP_COL_EL    = 4'd4,
      STEP_PAGE_CMD  = 4'd5,
      STEP_PAGE_SH   = 4'd6,
      STEP_PAGE_SL   = 4'd7,
      STEP_PAGE_EH   = 4'd8,
      STEP_PAGE_EL   = 4'd9
   } step_type;

   // clipped window, all 16-bit patterns
   typedef struct packed {
      logic [15:0] col_start;
      logic [15:0] col_end;
      logic [15:0] page_start;
      logic [15:0] page_end;
   } window_type;

endpackage

>>> sv/lwcg_clip.sv
// clips one axis of the drawing rectangle to the panel size
// combinational; no package dependencies
module lwcg_clip (
   input  logic signed [15:0] origin,
   input  logic        [15:0] extent,
   input  logic        [11:0] size,
   output logic        [15:0] start_word,
   output logic        [15:0] end_word
);

   logic signed [12:0] size_m1;
   logic signed [16:0] origin_w;
   logic signed [16:0] size_m1_w;
   logic signed [12:0] start_s;
   logic signed [17:0] sum;
   logic signed [17:0] size_w;
   logic signed [17:0] sum_m1;
   logic               cut;

   always_comb begin
      size_m1   = $signed({1'b0, size}) - 13'sd1;
      origin_w  = {origin[15], origin};
      size_m1_w = {{4{size_m1[12]}}, size_m1};

      // clamp origin to 0..size-1 (size-1 may be -1 for a zero panel)
      if (origin[15]) begin
         start_s = 13'sd0;
      end else if (origin_w > size_m1_w) begin
         start_s = size_m1;
      end else begin
         start_s = $signed(origin[12:0]);
      end

      sum    = {{5{start_s[12]}}, start_s} + $signed({2'b00, extent});
      size_w = $signed({6'b0, size});
      cut    = sum > size_w;
      sum_m1 = sum - 18'sd1;

      start_word = {{3{start_s[12]}}, start_s};
      // a cut extent always ends on the last panel line
      end_word = cut ? {{3{size_m1[12]}}, size_m1} : sum_m1[15:0];
   end

endmodule

>>> sv/lwcg_serializer.sv
// holds one clipped window and sends its ten command bytes one per transaction
// depends on lwcg_pkg
module lwcg_serializer
   import lwcg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  window_type  window,
   input  logic        load_valid,
   output logic        load_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_data,
   output logic        rsp_last
);

   logic       busy_ff, busy_in;
   step_type   step_ff, step_in;
   window_type win_ff, win_in;
   logic       fire;
   logic       done;
   logic       load;

   always_comb begin
      fire       = busy_ff && !rsp_stall;
      done       = fire && (step_ff == STEP_PAGE_EL);
      load_ready = !busy_ff || done;
      load       = load_valid && load_ready;

      busy_in = busy_ff;
      step_in = step_ff;
      win_in  = win_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = STEP_COL_CMD;
         win_in  = window;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         step_in = step_type'(step_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_COL_CMD;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      win_ff <= win_in;
   end

   // byte select from the held window
   always_comb begin
      rsp_is_data = 1'b1;
      unique case (step_ff)
         STEP_COL_CMD: begin
            rsp_out_byte = CMD_COLUMN_SET;
            rsp_is_data  = 1'b0;
         end
         STEP_COL_SH:  rsp_out_byte = win_ff.col_start[15:8];
         STEP_COL_SL:  rsp_out_byte = win_ff.col_start[7:0];
         STEP_COL_EH:  rsp_out_byte = win_ff.col_end[15:8];
         STEP_COL_EL:  rsp_out_byte = win_ff.col_end[7:0];
         STEP_PAGE_CMD: begin
            rsp_out_byte = CMD_PAGE_SET;
            rsp_is_data  = 1'b0;
         end
         STEP_PAGE_SH: rsp_out_byte = win_ff.page_start[15:8];
         STEP_PAGE_SL: rsp_out_byte = win_ff.page_start[7:0];
         STEP_PAGE_EH: rsp_out_byte = win_ff.page_end[15:8];
         STEP_PAGE_EL: rsp_out_byte = win_ff.page_end[7:0];
         default:      rsp_out_byte = win_ff.page_end[7:0];
      endcase
      rsp_last  = (step_ff == STEP_PAGE_EL);
      rsp_valid = busy_ff;
   end

endmodule

>>> sv/lcd_window_command_generator_top.sv
// top level of the lcd window command generator: input register, clip, serializer
// depends on lwcg_pkg, lwcg_clip, lwcg_serializer
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | origin_x, origin_y, rect_width, rect_height
//   rsp     | out       | rsp_valid / rsp_stall  | out_byte, is_data, last
//   csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
// each rectangle gives ten bytes, one per cycle while rsp is not stalled
// the single output byte per cycle of the serializer sets that rate
// one rectangle waits in the input register while the previous run is sent
// when idle, a req transaction passes the input and window registers before the first byte
// reset clears valid flags and loads the panel size to 240 x 320
// a stall on rsp holds the current byte; req stalls once the input register is full
module lcd_window_command_generator_top
   import lwcg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // rectangle in
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,
   input  logic        [15:0] req_rect_width,
   input  logic        [15:0] req_rect_height,
   // command bytes out
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [7:0]  rsp_out_byte,
   output logic               rsp_is_data,
   output logic               rsp_last,
   // configuration writes
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic        [11:0] csr_write_data
);

   // panel size registers
   logic [11:0] panel_width_ff, panel_width_in;
   logic [11:0] panel_height_ff, panel_height_in;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic signed [15:0] origin_x_ff, origin_x_in;
   logic signed [15:0] origin_y_ff, origin_y_in;
   logic        [15:0] rect_width_ff, rect_width_in;
   logic        [15:0] rect_height_ff, rect_height_in;

   logic        load_valid;
   logic        load_ready;
   logic [15:0] col_start;
   logic [15:0] col_end;
   logic [15:0] page_start;
   logic [15:0] page_end;
   window_type  window;
   logic        req_take;

   always_comb begin
      panel_width_in  = panel_width_ff;
      panel_height_in = panel_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PANEL_WIDTH:  panel_width_in  = csr_write_data;
            CSR_PANEL_HEIGHT: panel_height_in = csr_write_data;
            default:          panel_width_in  = panel_width_ff;
         endcase
      end
   end

   // input register frees up in the same cycle the serializer takes its content
   always_comb begin
      load_valid = in_valid_ff;
      req_stall  = in_valid_ff && !load_ready;
      req_take   = req_valid && !req_stall;

      in_valid_in    = in_valid_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      rect_width_in  = rect_width_ff;
      rect_height_in = rect_height_ff;
      if (req_take) begin
         in_valid_in    = 1'b1;
         origin_x_in    = req_origin_x;
         origin_y_in    = req_origin_y;
         rect_width_in  = req_rect_width;
         rect_height_in = req_rect_height;
      end else if (load_valid && load_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff  <= PANEL_WIDTH_RESET;
         panel_height_ff <= PANEL_HEIGHT_RESET;
         in_valid_ff     <= 1'b0;
      end else begin
         panel_width_ff  <= panel_width_in;
         panel_height_ff <= panel_height_in;
         in_valid_ff     <= in_valid_in;
      end
      origin_x_ff    <= origin_x_in;
      origin_y_ff    <= origin_y_in;
      rect_width_ff  <= rect_width_in;
      rect_height_ff <= rect_height_in;
   end

   // column axis
   lwcg_clip u_clip_col (
      .origin     (origin_x_ff),
      .extent     (rect_width_ff),
      .size       (panel_width_ff),
      .start_word (col_start),
      .end_word   (col_end)
   );

   // page axis
   lwcg_clip u_clip_page (
      .origin     (origin_y_ff),
      .extent     (rect_height_ff),
      .size       (panel_height_ff),
      .start_word (page_start),
      .end_word   (page_end)
   );

   assign window = {col_start, col_end, page_start, page_end};

   // ten-byte sender with its own window register
   lwcg_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .window       (window),
      .load_valid   (load_valid),
      .load_ready   (load_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last)
   );

endmodule

>>> sv/lwcg_checker.sv
// port-level checks for the lcd window command generator, bound to the top level
// depends on lwcg_pkg and lcd_window_command_generator_top_defines.svh
`include "lcd_window_command_generator_top_defines.svh"

module lwcg_checker
   import lwcg_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_data,
   input logic       rsp_last
);

   // a held byte keeps its value
   `LWCG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_data) && $stable(rsp_last))

   // nothing goes out right after reset
   `LWCG_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

   // command bytes are only the two opcodes
   `LWCG_ASSERT_NOW(a_cmd_code, clock, reset, rsp_valid && !rsp_is_data, rsp_out_byte == CMD_COLUMN_SET || rsp_out_byte == CMD_PAGE_SET)

   // the final byte of a run is a parameter byte
   `LWCG_ASSERT_NOW(a_last_data, clock, reset, rsp_valid && rsp_last, rsp_is_data)

endmodule

bind lcd_window_command_generator_top lwcg_checker u_lwcg_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_is_data  (rsp_is_data),
   .rsp_last     (rsp_last)
);

>>> tb/sv/tb_lcd_window_command_generator_top.sv
// self-checking testbench for lcd_window_command_generator_top: a directed table, then random
// rectangles over several panel sizes and idle/stall mixes; depends on lwcg_pkg and the rtl
module tb_lcd_window_command_generator_top
   import lwcg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // one byte of the command stream as it leaves the block
   typedef struct packed {
      logic [7:0] code_byte;
      logic       data_flag;
      logic       last_flag;
   } cmd_byte_type;

   // one directed rectangle, with the panel size it runs under
   // when known_win is set the window is typed in, else the clip predictor fills it
   typedef struct packed {
      logic [11:0] panel_w;
      logic [11:0] panel_h;
      logic [15:0] org_x;
      logic [15:0] org_y;
      logic [15:0] ext_x;
      logic [15:0] ext_y;
      logic        known_win;
      window_type  win;
   } window_case_type;

   localparam int NUM_CASES      = 20;
   localparam int PHASE_ITEMS    = 25;
   localparam int MAX_REPORTS    = 10;

   window_case_type case_table [0:NUM_CASES-1] = '{
      // reset panel 240 x 320, no write yet
      '{12'd240, 12'd320, 16'd0, 16'd0, 16'd1, 16'd1, 1'b1,
        '{16'd0, 16'd0, 16'd0, 16'd0}},
      '{12'd240, 12'd320, 16'd0, 16'd0, 16'd240, 16'd320, 1'b1,
        '{16'd0, 16'd239, 16'd0, 16'd319}},
      // most negative origin, largest extent
      '{12'd240, 12'd320, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 1'b1,
        '{16'd0, 16'd239, 16'd0, 16'd319}},
      // most positive origin clamps to the last column and row
      '{12'd240, 12'd320, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 1'b1,
        '{16'd239, 16'd239, 16'd319, 16'd319}},
      // zero extent wraps the end below the start
      '{12'd240, 12'd320, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1,
        '{16'd0, 16'hffff, 16'd0, 16'hffff}},
      '{12'd240, 12'd320, 16'd100, 16'd200, 16'd0, 16'd0, 1'b1,
        '{16'd100, 16'd99, 16'd200, 16'd199}},
      '{12'd240, 12'd320, 16'hffff, 16'hffff, 16'd10, 16'd10, 1'b1,
        '{16'd0, 16'd9, 16'd0, 16'd9}},
      '{12'd240, 12'd320, 16'd239, 16'd319, 16'd1, 16'd1, 1'b1,
        '{16'd239, 16'd239, 16'd319, 16'd319}},
      '{12'd240, 12'd320, 16'd240, 16'd320, 16'd5, 16'd5, 1'b1,
        '{16'd239, 16'd239, 16'd319, 16'd319}},
      '{12'd240, 12'd320, 16'd10, 16'd20, 16'd30, 16'd40, 1'b1,
        '{16'd10, 16'd39, 16'd20, 16'd59}},
      '{12'd240, 12'd320, 16'd200, 16'd300, 16'd100, 16'd50, 1'b0, '0},
      // largest panel
      '{12'hfff, 12'hfff, 16'd0, 16'd0, 16'hffff, 16'hffff, 1'b1,
        '{16'd0, 16'd4094, 16'd0, 16'd4094}},
      '{12'hfff, 12'hfff, 16'h7fff, 16'hfffb, 16'd4095, 16'd1, 1'b1,
        '{16'd4094, 16'd4094, 16'd0, 16'd0}},
      '{12'hfff, 12'hfff, 16'h5a5a, 16'h0a5a, 16'ha5a5, 16'h5a5a, 1'b0, '0},
      // one pixel panel
      '{12'd1, 12'd1, 16'd5, 16'hfffb, 16'd3, 16'd0, 1'b1,
        '{16'd0, 16'd0, 16'd0, 16'hffff}},
      '{12'd1, 12'd1, 16'h8000, 16'h7fff, 16'hffff, 16'hffff, 1'b0, '0},
      // zero sized panel: upper clamp bound becomes -1
      '{12'd0, 12'd0, 16'd0, 16'd0, 16'd5, 16'd0, 1'b1,
        '{16'hffff, 16'hffff, 16'hffff, 16'hfffe}},
      '{12'd0, 12'd0, 16'hfffd, 16'd100, 16'd0, 16'hffff, 1'b1,
        '{16'd0, 16'hffff, 16'hffff, 16'hffff}},
      // mixed sizes
      '{12'hfff, 12'd0, 16'd4000, 16'h8000, 16'd200, 16'd7, 1'b0, '0},
      '{12'd0, 12'hfff, 16'h7fff, 16'd17, 16'd0, 16'd5000, 1'b0, '0}
   };

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // dut inputs, all known from time zero
   logic               req_valid        = 1'b0;
   logic signed [15:0] req_origin_x     = '0;
   logic signed [15:0] req_origin_y     = '0;
   logic        [15:0] req_rect_width   = '0;
   logic        [15:0] req_rect_height  = '0;
   logic               rsp_stall        = 1'b0;
   logic               csr_write_enable = 1'b0;
   logic               csr_index        = CSR_PANEL_WIDTH;
   logic        [11:0] csr_write_data   = '0;

   // dut outputs
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_data;
   logic       rsp_last;

   lcd_window_command_generator_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor copy of the panel size registers
   logic [11:0] panel_cols = PANEL_WIDTH_RESET;
   logic [11:0] panel_rows = PANEL_HEIGHT_RESET;

   // command bytes still owed by the block, oldest first
   cmd_byte_type pending_bytes [$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatches = 0;

   // clamp one axis into the panel and cut its extent at the edge
   // start and end come back as 16-bit two's complement patterns
   function automatic void clip_axis(input logic signed [15:0] origin, input logic [15:0] extent,
                                     input logic [11:0] size, output logic [15:0] axis_start,
                                     output logic [15:0] axis_stop);
      int sz;
      int s;
      int x;
      int e;
      sz = size;
      s  = origin;
      x  = extent;
      if (s < 0) begin
         s = 0;
      end else if (s > sz - 1) begin
         s = sz - 1;
      end
      // the cut length is masked to 16 bits, so the end falls on the last panel line
      if (s + x > sz) begin
         x = (sz - s) & 32'hffff;
      end
      e = s + x - 1;
      axis_start = s[15:0];
      axis_stop  = e[15:0];
   endfunction

   function automatic window_type clip_window(input logic [15:0] ox, input logic [15:0] oy,
                                              input logic [15:0] wx, input logic [15:0] hy);
      window_type w;
      clip_axis(ox, wx, panel_cols, w.col_start, w.col_end);
      clip_axis(oy, hy, panel_rows, w.page_start, w.page_end);
      return w;
   endfunction

   // queue the ten bytes that set one window
   function automatic void queue_window_bytes(input window_type w);
      pending_bytes.push_back('{CMD_COLUMN_SET, 1'b0, 1'b0});
      pending_bytes.push_back('{w.col_start[15:8], 1'b1, 1'b0});
      pending_bytes.push_back('{w.col_start[7:0], 1'b1, 1'b0});
      pending_bytes.push_back('{w.col_end[15:8], 1'b1, 1'b0});
      pending_bytes.push_back('{w.col_end[7:0], 1'b1, 1'b0});
      pending_bytes.push_back('{CMD_PAGE_SET, 1'b0, 1'b0});
      pending_bytes.push_back('{w.page_start[15:8], 1'b1, 1'b0});
      pending_bytes.push_back('{w.page_start[7:0], 1'b1, 1'b0});
      pending_bytes.push_back('{w.page_end[15:8], 1'b1, 1'b0});
      pending_bytes.push_back('{w.page_end[7:0], 1'b1, 1'b1});
   endfunction

   // random origin: anywhere, inside, around the far edge, just negative, or extreme
   function automatic logic [15:0] pick_origin(input logic [11:0] size);
      int sel;
      sel = $urandom_range(0, 4);
      case (sel)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, size));
         2: return 16'(int'(size) - 2 + int'($urandom_range(0, 4)));
         3: return 16'(-int'($urandom_range(1, 16)));
         default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      endcase
   endfunction

   // random extent: anywhere, up to two past the panel size, zero or one, all ones, or short
   function automatic logic [15:0] pick_extent(input logic [11:0] size);
      int sel;
      sel = $urandom_range(0, 4);
      case (sel)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, int'(size) + 2));
         2: return 16'($urandom_range(0, 1));
         3: return 16'hffff;
         default: return 16'($urandom_range(1, 16));
      endcase
   endfunction

   // random panel dimension, weighted toward small sizes where clipping bites
   function automatic logic [11:0] pick_panel_size();
      int sel;
      sel = $urandom_range(0, 3);
      case (sel)
         0: return 12'($urandom_range(1, 16));
         1: return 12'($urandom_range(17, 4095));
         2: return 12'hfff;
         default: return 12'($urandom_range(0, 2));
      endcase
   endfunction

   // offer one rectangle, hold it through stalls, queue its bytes once taken
   // valid stays high on return so a back-to-back transaction needs no second assignment
   task automatic send_rect(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [15:0] wx, input logic [15:0] hy,
                            input window_type win);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_origin_x    <= ox;
      req_origin_y    <= oy;
      req_rect_width  <= wx;
      req_rect_height <= hy;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      queue_window_bytes(win);
   endtask

   // stop offering and hold off until every owed byte has come out
   task automatic drain_bytes();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // write both panel registers; only called with the block drained
   task automatic write_panel(input logic [11:0] cols, input logic [11:0] rows);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PANEL_WIDTH;
      csr_write_data   <= cols;
      @(posedge clock);
      csr_index        <= CSR_PANEL_HEIGHT;
      csr_write_data   <= rows;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      panel_cols = cols;
      panel_rows = rows;
   endtask

   // receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // byte checker: every transaction on rsp is matched against the oldest owed byte
   cmd_byte_type want_byte;
   cmd_byte_type seen_byte;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_byte = '{rsp_out_byte, rsp_is_data, rsp_last};
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected byte %h data %b last %b", rsp_out_byte, rsp_is_data,
                        rsp_last);
            end
         end else begin
            want_byte = pending_bytes.pop_front();
            if (seen_byte !== want_byte) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("byte mismatch: expected %h data %b last %b, got %h data %b last %b",
                           want_byte.code_byte, want_byte.data_flag, want_byte.last_flag,
                           seen_byte.code_byte, seen_byte.data_flag, seen_byte.last_flag);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [15:0] ox;
      logic [15:0] oy;
      logic [15:0] wx;
      logic [15:0] hy;
      window_type  win;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling; the panel is rewritten only when a row asks for a new size
      foreach (case_table[i]) begin
         if (case_table[i].panel_w != panel_cols || case_table[i].panel_h != panel_rows) begin
            drain_bytes();
            write_panel(case_table[i].panel_w, case_table[i].panel_h);
         end
         if (case_table[i].known_win) begin
            win = case_table[i].win;
         end else begin
            win = clip_window(case_table[i].org_x, case_table[i].org_y,
                              case_table[i].ext_x, case_table[i].ext_y);
         end
         send_rect(case_table[i].org_x, case_table[i].org_y,
                   case_table[i].ext_x, case_table[i].ext_y, win);
      end

      // random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         // pausing here lets the pipeline drain completely before the panel changes
         drain_bytes();
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 66;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 66;
            end
            default: begin
               sender_idle_pct    = 33;
               receiver_stall_pct = 33;
            end
         endcase
         write_panel(pick_panel_size(), pick_panel_size());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            ox  = pick_origin(panel_cols);
            oy  = pick_origin(panel_rows);
            wx  = pick_extent(panel_cols);
            hy  = pick_extent(panel_rows);
            win = clip_window(ox, oy, wx, hy);
            send_rect(ox, oy, wx, hy, win);
         end
      end

      // wind down: everything owed must arrive, then a short quiet spell
      drain_bytes();
      receiver_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("lcd_window_command_generator_top regression: pass");
      end else begin
         $display("lcd_window_command_generator_top regression: fail");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("lcd_window_command_generator_top regression: fail");
      $finish;
   end

endmodule
